@@ sv/tick_reorder_queue_unit_defines.svh @@
// Assertion macros for the tick reorder queue checker.
// Both macros expect a signal named clk in the scope that uses them; TRQ_ASSERT also needs rst.
`ifndef TICK_REORDER_QUEUE_UNIT_DEFINES_SVH
`define TICK_REORDER_QUEUE_UNIT_DEFINES_SVH

// Clocked assertion, switched off while rst is high.
`define TRQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Clocked assertion that also holds while rst is high.
`define TRQ_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

@@ sv/trq_pkg.sv @@
// Shared types and codes for the tick reorder queue.
// No dependencies.
package trq_pkg;

  localparam int TickW = 64;
  localparam int DropW = 7;

  localparam logic [1:0] KIND_ACCEPT  = 2'd0;
  localparam logic [1:0] KIND_CONSUME = 2'd1;
  localparam logic [1:0] KIND_CLEAR   = 2'd2;
  localparam logic [1:0] KIND_UNUSED  = 2'd3;

  localparam logic [2:0] CODE_ACCEPTED  = 3'd0;
  localparam logic [2:0] CODE_STALE     = 3'd1;
  localparam logic [2:0] CODE_HORIZON   = 3'd2;
  localparam logic [2:0] CODE_DUPLICATE = 3'd3;
  localparam logic [2:0] CODE_FULL      = 3'd4;
  localparam logic [2:0] CODE_DELIVERED = 3'd5;
  localparam logic [2:0] CODE_STARVED   = 3'd6;
  localparam logic [2:0] CODE_CLEARED   = 3'd7;

  typedef struct packed {
    logic [1:0]       kind;
    logic [TickW-1:0] tick;
    logic [31:0]      action_bits;
    logic [31:0]      move_x;
    logic [31:0]      move_y;
    logic [31:0]      look_yaw;
    logic [31:0]      look_pitch;
    logic [7:0]       sub_tick;
  } trq_cmd_t;

  typedef struct packed {
    logic [31:0] action_bits;
    logic [31:0] move_x;
    logic [31:0] move_y;
    logic [31:0] look_yaw;
    logic [31:0] look_pitch;
    logic [7:0]  sub_tick;
  } trq_payload_t;

  typedef struct packed {
    logic [TickW-1:0] tick;
    trq_payload_t     payload;
  } trq_entry_t;

  typedef struct packed {
    logic [2:0]       code;
    logic [31:0]      out_action_bits;
    logic [31:0]      out_move_x;
    logic [31:0]      out_move_y;
    logic [31:0]      out_look_yaw;
    logic [31:0]      out_look_pitch;
    logic [7:0]       out_sub_tick;
    logic [31:0]      starved_count;
    logic [DropW-1:0] dropped_late;
  } trq_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_INSERT,
    ST_DROP_RD,
    ST_DROP_CMP,
    ST_DONE
  } trq_state_t;

endpackage

@@ sv/tick_reorder_queue_unit.sv @@
// Tick reorder queue: jitter buffer of commands kept sorted by ascending tick.
// Depends on trq_pkg.
// Channels: cmd (cmd_valid/cmd_stall, trq_cmd_t) in, rsp (rsp_valid/rsp_stall,
// trq_rsp_t) out; a transaction moves when valid is high and stall is low.
// Every command of kind accept, consume or clear gives exactly one response;
// the unused kind is taken and dropped without a response.
// Entries sit in a circular memory (head pointer plus count) with one port.
// A small sequencer steps a single 64-bit subtract/compare unit over it.
// Steps from cmd transaction to rsp_valid:
//   accept:  stale or beyond horizon goes straight to the response; else scan the
//            entries in order, stop on a duplicate or when full, else shift the
//            later entries up one slot and insert the command (or append it)
//   consume: drop the late entries from the head, then deliver or answer starved
//   clear:   resets the queue state and goes straight to the response
// cmd_stall is high from the cycle after a transaction (unused kind apart) until
// its response is in the output register, so a new command is taken only after the
// last one is answered; the next command is taken while rsp waits. A stalled rsp holds.
// Reset empties the queue and clears the applied tick, the applied flag and the
// starved counter; no memory sweep is needed.
module tick_reorder_queue_unit #(
  parameter int DEPTH     = 64,
  parameter int LOOKAHEAD = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  trq_pkg::trq_cmd_t cmd,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output trq_pkg::trq_rsp_t rsp
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  trq_pkg::trq_state_t state, state_next;

  trq_pkg::trq_entry_t mem [DEPTH];
  trq_pkg::trq_entry_t rd_q;
  trq_pkg::trq_entry_t wr_data;
  logic                mem_we;

  trq_pkg::trq_cmd_t   item;
  trq_pkg::trq_rsp_t   res;
  logic [CW-1:0]       count;
  logic [CW-1:0]       idx;
  logic [CW-1:0]       sidx;
  logic [CW-1:0]       log_idx;
  logic [AW-1:0]       head;
  logic [AW-1:0]       head_inc;
  logic [AW:0]         addr_sum;
  logic [AW-1:0]       phys_addr;
  logic [trq_pkg::TickW-1:0] applied_tick;
  logic                applied_flag;
  logic [31:0]         starved;
  logic [31:0]         starved_sat;
  logic [trq_pkg::DropW-1:0] dropped;

  logic [trq_pkg::TickW-1:0] cmp_b;
  logic [trq_pkg::TickW:0]   diff;
  logic                ent_eq;
  logic                ent_lt;
  logic                stale;
  logic                horizon;
  logic                full;
  logic                rsp_free;

  function automatic trq_pkg::trq_rsp_t mk_rsp(
    input logic [2:0]                code,
    input trq_pkg::trq_payload_t     p,
    input logic [31:0]               starved_cnt,
    input logic [trq_pkg::DropW-1:0] drop_cnt
  );
    trq_pkg::trq_rsp_t r;
    r.code            = code;
    r.out_action_bits = p.action_bits;
    r.out_move_x      = p.move_x;
    r.out_move_y      = p.move_y;
    r.out_look_yaw    = p.look_yaw;
    r.out_look_pitch  = p.look_pitch;
    r.out_sub_tick    = p.sub_tick;
    r.starved_count   = starved_cnt;
    r.dropped_late    = drop_cnt;
    return r;
  endfunction

  // shared compare unit: command tick against applied tick or stored tick
  assign cmp_b   = (state == trq_pkg::ST_CHECK) ? applied_tick : rd_q.tick;
  assign diff    = {1'b0, item.tick} - {1'b0, cmp_b};
  assign ent_eq  = (diff[trq_pkg::TickW-1:0] == '0);
  assign ent_lt  = !diff[trq_pkg::TickW] && !ent_eq;
  assign stale   = diff[trq_pkg::TickW] || ent_eq;
  assign horizon = (diff[trq_pkg::TickW-1:0] > trq_pkg::TickW'(LOOKAHEAD));

  assign full        = (count == CW'(DEPTH));
  assign rsp_free    = !rsp_valid || !rsp_stall;
  assign starved_sat = (starved == '1) ? starved : starved + 32'd1;
  assign head_inc    = (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);
  assign cmd_stall   = (state != trq_pkg::ST_IDLE);

  // logical slot to memory address
  assign addr_sum  = (AW + 1)'(head) + (AW + 1)'(log_idx);
  always_comb begin
    if (addr_sum >= (AW + 1)'(DEPTH)) begin
      phys_addr = addr_sum[AW-1:0] - AW'(DEPTH);
    end else begin
      phys_addr = addr_sum[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= trq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    log_idx    = idx;
    mem_we     = 1'b0;
    wr_data    = rd_q;
    unique case (state)
      trq_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          priority if (cmd.kind == trq_pkg::KIND_ACCEPT) begin
            state_next = trq_pkg::ST_CHECK;
          end else if (cmd.kind == trq_pkg::KIND_CONSUME) begin
            state_next = trq_pkg::ST_DROP_RD;
          end else if (cmd.kind == trq_pkg::KIND_CLEAR) begin
            state_next = trq_pkg::ST_DONE;
          end else begin
            state_next = trq_pkg::ST_IDLE;
          end
        end
      end
      trq_pkg::ST_CHECK: begin
        if (applied_flag && (stale || horizon)) begin
          state_next = trq_pkg::ST_DONE;
        end else begin
          state_next = trq_pkg::ST_SCAN_RD;
        end
      end
      trq_pkg::ST_SCAN_RD: begin
        log_idx = idx;
        if (idx == count) begin
          state_next = full ? trq_pkg::ST_DONE : trq_pkg::ST_SHIFT_RD;
        end else begin
          state_next = trq_pkg::ST_SCAN_CMP;
        end
      end
      trq_pkg::ST_SCAN_CMP: begin
        priority if (ent_lt) begin
          state_next = trq_pkg::ST_SCAN_RD;
        end else if (ent_eq || full) begin
          state_next = trq_pkg::ST_DONE;
        end else begin
          state_next = trq_pkg::ST_SHIFT_RD;
        end
      end
      trq_pkg::ST_SHIFT_RD: begin
        log_idx = sidx - CW'(1);
        if (sidx == idx) begin
          state_next = trq_pkg::ST_INSERT;
        end else begin
          state_next = trq_pkg::ST_SHIFT_WR;
        end
      end
      trq_pkg::ST_SHIFT_WR: begin
        log_idx    = sidx;
        mem_we     = 1'b1;
        wr_data    = rd_q;
        state_next = trq_pkg::ST_SHIFT_RD;
      end
      trq_pkg::ST_INSERT: begin
        log_idx              = idx;
        mem_we               = 1'b1;
        wr_data.tick         = item.tick;
        wr_data.payload      = {item.action_bits, item.move_x, item.move_y,
                                item.look_yaw, item.look_pitch, item.sub_tick};
        state_next           = trq_pkg::ST_DONE;
      end
      trq_pkg::ST_DROP_RD: begin
        log_idx = '0;
        if (count == '0) begin
          state_next = trq_pkg::ST_DONE;
        end else begin
          state_next = trq_pkg::ST_DROP_CMP;
        end
      end
      trq_pkg::ST_DROP_CMP: begin
        if (ent_lt) begin
          state_next = trq_pkg::ST_DROP_RD;
        end else begin
          state_next = trq_pkg::ST_DONE;
        end
      end
      trq_pkg::ST_DONE: begin
        if (rsp_free) begin
          state_next = trq_pkg::ST_IDLE;
        end
      end
      default: state_next = trq_pkg::ST_IDLE;
    endcase
  end

  // entry store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[phys_addr] <= wr_data;
    end
    rd_q <= mem[phys_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      head         <= '0;
      applied_tick <= '0;
      applied_flag <= 1'b0;
      starved      <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && state != trq_pkg::ST_DONE) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        trq_pkg::ST_IDLE: begin
          if (cmd_valid && cmd.kind == trq_pkg::KIND_CLEAR) begin
            count        <= '0;
            head         <= '0;
            applied_tick <= '0;
            applied_flag <= 1'b0;
            starved      <= '0;
          end
        end
        trq_pkg::ST_INSERT: begin
          count <= count + CW'(1);
        end
        trq_pkg::ST_DROP_RD: begin
          if (count == '0) begin
            starved <= starved_sat;
          end
        end
        trq_pkg::ST_DROP_CMP: begin
          if (ent_lt || ent_eq) begin
            head  <= head_inc;
            count <= count - CW'(1);
          end
          if (ent_eq) begin
            applied_tick <= item.tick;
            applied_flag <= 1'b1;
          end
          if (!ent_lt && !ent_eq) begin
            starved <= starved_sat;
          end
        end
        trq_pkg::ST_DONE: begin
          if (rsp_free) begin
            rsp_valid <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // working registers and response
  always_ff @(posedge clk) begin
    unique case (state)
      trq_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          item    <= cmd;
          idx     <= '0;
          dropped <= '0;
          res     <= mk_rsp(trq_pkg::CODE_CLEARED, '0, '0, '0);
        end
      end
      trq_pkg::ST_CHECK: begin
        res <= mk_rsp(stale ? trq_pkg::CODE_STALE : trq_pkg::CODE_HORIZON, '0, starved, '0);
      end
      trq_pkg::ST_SCAN_RD: begin
        if (idx == count) begin
          sidx <= count;
          res  <= mk_rsp(trq_pkg::CODE_FULL, '0, starved, '0);
        end
      end
      trq_pkg::ST_SCAN_CMP: begin
        if (ent_lt) begin
          idx <= idx + CW'(1);
        end else begin
          sidx <= count;
          res  <= mk_rsp(ent_eq ? trq_pkg::CODE_DUPLICATE : trq_pkg::CODE_FULL, '0,
                         starved, '0);
        end
      end
      trq_pkg::ST_SHIFT_WR: begin
        sidx <= sidx - CW'(1);
      end
      trq_pkg::ST_INSERT: begin
        res <= mk_rsp(trq_pkg::CODE_ACCEPTED, '0, starved, '0);
      end
      trq_pkg::ST_DROP_RD: begin
        if (count == '0) begin
          res <= mk_rsp(trq_pkg::CODE_STARVED, '0, starved_sat, dropped);
        end
      end
      trq_pkg::ST_DROP_CMP: begin
        priority if (ent_lt) begin
          dropped <= dropped + trq_pkg::DropW'(1);
        end else if (ent_eq) begin
          res <= mk_rsp(trq_pkg::CODE_DELIVERED, rd_q.payload, starved, dropped);
        end else begin
          res <= mk_rsp(trq_pkg::CODE_STARVED, '0, starved_sat, dropped);
        end
      end
      trq_pkg::ST_DONE: begin
        if (rsp_free) begin
          rsp <= res;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ sv/trq_checker.sv @@
// Port-level checks for tick_reorder_queue_unit, attached by bind.
// Depends on trq_pkg and tick_reorder_queue_unit_defines.svh.
`include "tick_reorder_queue_unit_defines.svh"

module trq_checker (
  input logic              clk,
  input logic              rst,
  input logic              cmd_valid,
  input logic              cmd_stall,
  input trq_pkg::trq_cmd_t cmd,
  input logic              rsp_valid,
  input logic              rsp_stall,
  input trq_pkg::trq_rsp_t rsp
);

  `TRQ_ASSERT_RST(a_reset_idle, rst |=> !rsp_valid && !cmd_stall, "not idle after reset")

  `TRQ_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp), "rsp changed while stalled")

  `TRQ_ASSERT(a_busy_after_cmd, cmd_valid && !cmd_stall && cmd.kind != trq_pkg::KIND_UNUSED |=> cmd_stall, "transaction taken without going busy")

  `TRQ_ASSERT(a_payload_zero, rsp_valid && rsp.code != trq_pkg::CODE_DELIVERED |-> rsp.out_action_bits == '0 && rsp.out_move_x == '0 && rsp.out_move_y == '0 && rsp.out_look_yaw == '0 && rsp.out_look_pitch == '0 && rsp.out_sub_tick == '0, "payload on non-delivery response")

  `TRQ_ASSERT(a_drop_zero, rsp_valid && rsp.code != trq_pkg::CODE_DELIVERED && rsp.code != trq_pkg::CODE_STARVED |-> rsp.dropped_late == '0, "drop count on accept or clear")

endmodule

bind tick_reorder_queue_unit trq_checker u_trq_checker (.*);

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for tick_reorder_queue_unit: a directed table, partly with its own expected
// codes, then random accept/consume/clear/unused traffic with fill-up runs, scored by a behavioral queue model.
// Depends on trq_pkg and tick_reorder_queue_unit.
module testbench;

  localparam int QDEPTH = 64;
  localparam int QAHEAD = 64;
  localparam int RAND_CMDS = 1080;
  localparam int LONG_HOLD = 600;
  localparam int DRAIN_CYCLES = 2 * QDEPTH + 40;
  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam logic [trq_pkg::TickW-1:0] TICK_MAX = '1;

  localparam trq_pkg::trq_payload_t PAY_ZERO = '0;
  localparam trq_pkg::trq_payload_t PAY_ONES = '1;
  localparam trq_pkg::trq_payload_t PAY_A = {32'h8000_0001, 32'h3F80_0000, 32'hBF80_0000,
                                             32'h7F7F_FFFF, 32'h0000_0001, 8'h80};
  localparam trq_pkg::trq_payload_t PAY_B = {32'h5555_AAAA, 32'hAAAA_5555, 32'h0F0F_F0F0,
                                             32'hF0F0_0F0F, 32'h1234_5678, 8'h5A};

  typedef struct {
    logic [1:0]                kind;
    logic [trq_pkg::TickW-1:0] tick;
    trq_pkg::trq_payload_t     pay;
    bit                        typed;
    logic [2:0]                code;
    logic [31:0]               starved;
  } table_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cmd_valid = 1'b0;
  logic              cmd_stall;
  trq_pkg::trq_cmd_t cmd = '0;
  logic              rsp_valid;
  logic              rsp_stall = 1'b0;
  trq_pkg::trq_rsp_t rsp;

  // model state
  trq_pkg::trq_entry_t       held_q[$];
  logic [trq_pkg::TickW-1:0] last_applied = '0;
  bit                        applied_seen = 1'b0;
  logic [31:0]               starved_total = '0;
  trq_pkg::trq_rsp_t         due_rsp_q[$];

  int          errors = 0;
  int          checked = 0;
  int          issued = 0;
  int          max_dropped = 0;
  int          code_hits[8];
  int unsigned cycles = 0;
  bit          hold_long = 1'b0;
  bit          send_quiet = 1'b0;
  logic [trq_pkg::TickW-1:0] game_tick = '0;

  tick_reorder_queue_unit #(
    .DEPTH(QDEPTH),
    .LOOKAHEAD(QAHEAD)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one command to the model queue; returns 0 when no response is due.
  function automatic bit model_cmd(input trq_pkg::trq_cmd_t c, output trq_pkg::trq_rsp_t r);
    int pos;
    int dropped;
    trq_pkg::trq_entry_t ent;
    r = '0;
    pos = 0;
    dropped = 0;
    case (c.kind)
      trq_pkg::KIND_ACCEPT: begin
        if (applied_seen && c.tick <= last_applied) begin
          r.code = trq_pkg::CODE_STALE;
        end else if (applied_seen && (c.tick - last_applied) > 64'(QAHEAD)) begin
          r.code = trq_pkg::CODE_HORIZON;
        end else begin
          while (pos < held_q.size() && held_q[pos].tick < c.tick) pos++;
          if (pos < held_q.size() && held_q[pos].tick == c.tick) begin
            r.code = trq_pkg::CODE_DUPLICATE;
          end else if (held_q.size() >= QDEPTH) begin
            r.code = trq_pkg::CODE_FULL;
          end else begin
            ent.tick = c.tick;
            ent.payload = {c.action_bits, c.move_x, c.move_y, c.look_yaw, c.look_pitch,
                           c.sub_tick};
            held_q.insert(pos, ent);
            r.code = trq_pkg::CODE_ACCEPTED;
          end
        end
      end
      trq_pkg::KIND_CONSUME: begin
        while (held_q.size() > 0 && held_q[0].tick < c.tick) begin
          held_q.delete(0);
          dropped++;
        end
        if (held_q.size() == 0 || held_q[0].tick != c.tick) begin
          if (starved_total != '1) starved_total++;
          r.code = trq_pkg::CODE_STARVED;
        end else begin
          ent = held_q[0];
          held_q.delete(0);
          {r.out_action_bits, r.out_move_x, r.out_move_y, r.out_look_yaw,
           r.out_look_pitch, r.out_sub_tick} = ent.payload;
          last_applied = c.tick;
          applied_seen = 1'b1;
          r.code = trq_pkg::CODE_DELIVERED;
        end
        r.dropped_late = trq_pkg::DropW'(dropped);
      end
      trq_pkg::KIND_CLEAR: begin
        held_q.delete();
        last_applied = '0;
        applied_seen = 1'b0;
        starved_total = '0;
        r.code = trq_pkg::CODE_CLEARED;
      end
      default: return 1'b0;
    endcase
    r.starved_count = starved_total;
    return 1'b1;
  endfunction

  function automatic table_row_t dir_row(input logic [1:0] k,
                                         input logic [trq_pkg::TickW-1:0] t,
                                         input trq_pkg::trq_payload_t p, input bit ty = 1'b0,
                                         input logic [2:0] cd = '0,
                                         input logic [31:0] starv = '0);
    table_row_t row;
    row.kind = k;
    row.tick = t;
    row.pay = p;
    row.typed = ty;
    row.code = cd;
    row.starved = starv;
    return row;
  endfunction

  function automatic trq_pkg::trq_payload_t rand_payload();
    return {$urandom, $urandom, $urandom, $urandom, $urandom, 8'($urandom)};
  endfunction

  function automatic logic [trq_pkg::TickW-1:0] rand_tick();
    return {$urandom, $urandom};
  endfunction

  task automatic send_cmd(input trq_pkg::trq_cmd_t c, input bit typed = 1'b0,
                          input trq_pkg::trq_rsp_t typed_rsp = '0);
    int gap;
    trq_pkg::trq_rsp_t r;
    trq_pkg::trq_rsp_t due;
    gap = send_quiet ? 0 : int'($urandom_range(0, 17));
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd <= c;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    if (model_cmd(c, r)) begin
      due = typed ? typed_rsp : r;
      due_rsp_q.insert(due_rsp_q.size(), due);
      issued++;
    end
  endtask

  // Random traffic around a moving game tick.
  task automatic mixed_run(input int len);
    trq_pkg::trq_cmd_t c;
    int r;
    repeat (len) begin
      r = int'($urandom_range(0, 99));
      c = {trq_pkg::KIND_ACCEPT, game_tick, rand_payload()};
      if (r < 55) begin
        if (r < 4) c.tick = rand_tick();
        else if (r < 9) c.tick = game_tick - 64'($urandom_range(0, 3));
        else if (r < 35) c.tick = game_tick + 64'($urandom_range(1, 8));
        else c.tick = game_tick + 64'($urandom_range(1, QAHEAD + 8));
      end else if (r < 93) begin
        c.kind = trq_pkg::KIND_CONSUME;
        r = int'($urandom_range(0, 9));
        if (r < 6) game_tick = game_tick + 64'd1;
        else if (r < 9) game_tick = game_tick + 64'($urandom_range(2, 6));
        c.tick = game_tick;
      end else if (r < 96) begin
        c.kind = trq_pkg::KIND_CLEAR;
        r = int'($urandom_range(0, 3));
        if (r < 2) game_tick = 64'($urandom_range(0, 1000));
        else if (r == 2) game_tick = rand_tick();
        else game_tick = TICK_MAX - 64'($urandom_range(0, 80));
      end else begin
        c.kind = trq_pkg::KIND_UNUSED;
        c.tick = rand_tick();
      end
      send_cmd(c);
    end
  endtask

  // Clear, fill the store in scrambled order, overflow it, then flush with a consume.
  task automatic fill_run(input bit squeeze);
    trq_pkg::trq_cmd_t c;
    logic [trq_pkg::TickW-1:0] base;
    logic [trq_pkg::TickW-1:0] first_tick;
    int rot;
    base = 64'($urandom_range(0, 32'h7FFF_FFFF));
    rot = int'($urandom_range(0, QDEPTH - 1));
    send_cmd({trq_pkg::KIND_CLEAR, base, rand_payload()});
    if (squeeze) hold_long = 1'b1;
    for (int i = 0; i < QDEPTH; i++) begin
      c = {trq_pkg::KIND_ACCEPT,
           base + 64'(2 * ((i * 37 + rot) % QDEPTH)) + 64'($urandom_range(0, 1)),
           rand_payload()};
      if (i == 0) first_tick = c.tick;
      send_cmd(c);
    end
    send_cmd({trq_pkg::KIND_ACCEPT, base + 64'(2 * QDEPTH + 5), rand_payload()});
    send_cmd({trq_pkg::KIND_ACCEPT, first_tick, rand_payload()});
    game_tick = squeeze ? base + 64'(2 * QDEPTH + 10)
                        : base + 64'($urandom_range(0, 2 * QDEPTH + 10));
    send_cmd({trq_pkg::KIND_CONSUME, game_tick, rand_payload()});
  endtask

  task automatic cmp_field(input string name, input logic [63:0] e, a);
    if (a !== e) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, e, a);
    end
  endtask

  task automatic check_rsp(input trq_pkg::trq_rsp_t e, a);
    cmp_field("code", 64'(e.code), 64'(a.code));
    cmp_field("out_action_bits", 64'(e.out_action_bits), 64'(a.out_action_bits));
    cmp_field("out_move_x", 64'(e.out_move_x), 64'(a.out_move_x));
    cmp_field("out_move_y", 64'(e.out_move_y), 64'(a.out_move_y));
    cmp_field("out_look_yaw", 64'(e.out_look_yaw), 64'(a.out_look_yaw));
    cmp_field("out_look_pitch", 64'(e.out_look_pitch), 64'(a.out_look_pitch));
    cmp_field("out_sub_tick", 64'(e.out_sub_tick), 64'(a.out_sub_tick));
    cmp_field("starved_count", 64'(e.starved_count), 64'(a.starved_count));
    cmp_field("dropped_late", 64'(e.dropped_late), 64'(a.dropped_late));
    checked++;
    code_hits[e.code]++;
    if (int'(e.dropped_late) > max_dropped) max_dropped = int'(e.dropped_late);
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (due_rsp_q.size() == 0) begin
        errors++;
        $display("%0t: response with none expected, expected nothing, got %h", $time, rsp);
      end else begin
        check_rsp(due_rsp_q[0], rsp);
        due_rsp_q.delete(0);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d responses outstanding", $time, cycles,
               due_rsp_q.size());
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Response side: random hold-off per transaction, quiet stretches, one long squeeze.
  initial begin : receiver
    int hold;
    int quiet_left;
    quiet_left = 0;
    forever begin
      if (hold_long) begin
        hold = LONG_HOLD;
        hold_long = 1'b0;
      end else if (quiet_left > 0) begin
        hold = 0;
        quiet_left--;
      end else begin
        hold = int'($urandom_range(0, 17));
        if ($urandom_range(0, 29) == 0) quiet_left = int'($urandom_range(10, 40));
      end
      if (hold > 0) begin
        rsp_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        rsp_stall <= 1'b0;
      end
      @(posedge clk);
      while (!rsp_valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    table_row_t dir_table[$];
    trq_pkg::trq_rsp_t want;
    bit first;
    dir_table = {
      dir_row(trq_pkg::KIND_CONSUME, '0, PAY_ZERO, 1'b1, trq_pkg::CODE_STARVED, 1),
      dir_row(trq_pkg::KIND_ACCEPT, TICK_MAX, PAY_ONES, 1'b1, trq_pkg::CODE_ACCEPTED, 1),
      dir_row(trq_pkg::KIND_ACCEPT, TICK_MAX, PAY_A, 1'b1, trq_pkg::CODE_DUPLICATE, 1),
      dir_row(trq_pkg::KIND_ACCEPT, '0, PAY_ZERO, 1'b1, trq_pkg::CODE_ACCEPTED, 1),
      dir_row(trq_pkg::KIND_CONSUME, '0, PAY_ONES, 1'b1, trq_pkg::CODE_DELIVERED, 1),
      dir_row(trq_pkg::KIND_ACCEPT, '0, PAY_A, 1'b1, trq_pkg::CODE_STALE, 1),
      dir_row(trq_pkg::KIND_ACCEPT, 64'd65, PAY_A, 1'b1, trq_pkg::CODE_HORIZON, 1),
      dir_row(trq_pkg::KIND_ACCEPT, 64'd64, PAY_A),
      dir_row(trq_pkg::KIND_ACCEPT, 64'd1, PAY_B),
      dir_row(trq_pkg::KIND_ACCEPT, 64'd2, PAY_ONES),
      dir_row(trq_pkg::KIND_CONSUME, 64'd64, PAY_ZERO),
      dir_row(trq_pkg::KIND_CONSUME, 64'd70, PAY_ZERO),
      dir_row(trq_pkg::KIND_UNUSED, 64'd3, PAY_ONES),
      dir_row(trq_pkg::KIND_CLEAR, TICK_MAX, PAY_ONES, 1'b1, trq_pkg::CODE_CLEARED, 0),
      dir_row(trq_pkg::KIND_ACCEPT, TICK_MAX - 1, PAY_B),
      dir_row(trq_pkg::KIND_ACCEPT, TICK_MAX, PAY_A),
      dir_row(trq_pkg::KIND_CONSUME, TICK_MAX - 1, PAY_ZERO),
      dir_row(trq_pkg::KIND_ACCEPT, TICK_MAX - 1, PAY_A, 1'b1, trq_pkg::CODE_STALE, 0),
      dir_row(trq_pkg::KIND_CONSUME, TICK_MAX, PAY_ZERO),
      dir_row(trq_pkg::KIND_ACCEPT, 64'd5, PAY_A, 1'b1, trq_pkg::CODE_STALE, 0),
      dir_row(trq_pkg::KIND_CONSUME, TICK_MAX, PAY_ZERO),
      dir_row(trq_pkg::KIND_CLEAR, '0, PAY_ZERO, 1'b1, trq_pkg::CODE_CLEARED, 0)
    };
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_table[i]) begin
      want = '0;
      want.code = dir_table[i].code;
      want.starved_count = dir_table[i].starved;
      send_cmd({dir_table[i].kind, dir_table[i].tick, dir_table[i].pay},
               dir_table[i].typed, want);
    end

    first = 1'b1;
    while (issued < dir_table.size() + RAND_CMDS) begin
      send_quiet = ($urandom_range(0, 4) == 0);
      if (first || $urandom_range(0, 9) == 0) fill_run(first);
      else mixed_run(int'($urandom_range(20, 60)));
      first = 1'b0;
    end
    cmd_valid <= 1'b0;

    while (due_rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("testbench: %0d transactions answered, %0d checked, largest late drop %0d",
             issued, checked, max_dropped);
    $write("testbench: accepted %0d stale %0d horizon %0d dup %0d full %0d ",
           code_hits[trq_pkg::CODE_ACCEPTED], code_hits[trq_pkg::CODE_STALE],
           code_hits[trq_pkg::CODE_HORIZON], code_hits[trq_pkg::CODE_DUPLICATE],
           code_hits[trq_pkg::CODE_FULL]);
    $display("delivered %0d starved %0d cleared %0d",
             code_hits[trq_pkg::CODE_DELIVERED], code_hits[trq_pkg::CODE_STARVED],
             code_hits[trq_pkg::CODE_CLEARED]);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/trq_pkg.sv
sv/tick_reorder_queue_unit.sv
sv/trq_checker.sv
verif/testbench.sv
